/* src/stpq_pkg.sv */
// Shared types and constants of the strict-priority task queue.
package stpq_pkg;
   localparam int QUEUE_SLOTS     = 64;
   localparam int PRIORITY_LEVELS = 4;
   localparam int SLOT_W          = $clog2(QUEUE_SLOTS);
   localparam int SCAN_W          = $clog2(QUEUE_SLOTS + 1);
   localparam int LVL_W           = 2;
   localparam int CNT_W           = 7;
   localparam int ID_W            = 32;
   localparam int ENTRY_W         = LVL_W + ID_W;

   localparam logic [1:0] KIND_SUBMIT  = 2'd0;
   localparam logic [1:0] KIND_DEQUEUE = 2'd1;
   localparam logic [1:0] KIND_CANCEL  = 2'd2;
   localparam logic [1:0] KIND_NOP     = 2'd3;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_FULL      = 2'd1;
   localparam logic [1:0] STAT_EMPTY     = 2'd2;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

   localparam logic [1:0] CSR_QUEUE_LIMIT  = 2'd0;
   localparam logic [1:0] CSR_NORMAL_LEVEL = 2'd1;

   typedef struct packed {
      logic [1:0]      kind;
      logic [2:0]      priority_req;
      logic [ID_W-1:0] cancel_id;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [ID_W-1:0]  task_id;
      logic [LVL_W-1:0] level;
      logic [CNT_W-1:0] queued_total;
      logic [CNT_W-1:0] high_water;
      logic [ID_W-1:0]  submitted_count;
      logic [ID_W-1:0]  cancelled_count;
   } rsp_type;

   typedef struct packed {
      logic              load_req;
      logic              rd_en;
      logic [SLOT_W-1:0] rd_addr;
      logic              eval_en;
      logic [SLOT_W-1:0] eval_idx;
      logic              finish;
   } cmd_type;
endpackage

/* src/stpq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module stpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

/* src/stpq_ctrl.sv */
// Controller: accepts a request, sequences the slot scan and closes the item.
module stpq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_kind,
   input  logic             out_free,
   output stpq_pkg::cmd_type cmd
);
   import stpq_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_type;

   state_type         state_ff, state_in;
   logic [SCAN_W-1:0] cnt_ff, cnt_in;
   logic              eval_ff, eval_in;
   logic [SLOT_W-1:0] eval_idx_ff, eval_idx_in;
   logic              accept;
   logic              rd_en;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rd_en     = (state_ff == S_SCAN) && (cnt_ff < SCAN_W'(QUEUE_SLOTS));

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      eval_in     = 1'b0;
      eval_idx_in = cnt_ff[SLOT_W-1:0];
      unique case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               if (req_kind == KIND_DEQUEUE || req_kind == KIND_CANCEL) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SCAN: begin
            eval_in = rd_en;
            if (rd_en) begin
               cnt_in = cnt_ff + 1'b1;
            end else if (!eval_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         eval_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         eval_ff  <= eval_in;
      end
      eval_idx_ff <= eval_idx_in;
   end

   always_comb begin
      cmd.load_req = accept;
      cmd.rd_en    = rd_en;
      cmd.rd_addr  = cnt_ff[SLOT_W-1:0];
      cmd.eval_en  = eval_ff;
      cmd.eval_idx = eval_idx_ff;
      cmd.finish   = (state_ff == S_DONE) && out_free;
   end
endmodule

/* src/stpq_dp.sv */
// Datapath: slot store, scan comparison, counters, configuration and result register.
module stpq_dp (
   input  logic              clock,
   input  logic              reset,
   input  stpq_pkg::req_type  req_data,
   input  stpq_pkg::cmd_type  cmd,
   output logic              out_free,
   input  logic              csr_valid,
   input  logic [1:0]        csr_index,
   input  logic [6:0]        csr_wdata,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output stpq_pkg::rsp_type  rsp_data
);
   import stpq_pkg::*;

   logic [1:0]       kind_ff;
   logic [2:0]       prio_ff;
   logic [ID_W-1:0]  want_ff;
   logic [QUEUE_SLOTS-1:0] valid_ff, valid_in;
   logic [ID_W-1:0]  next_id_ff, next_id_in;
   logic [CNT_W-1:0] pending_ff, pending_in;
   logic [CNT_W-1:0] peak_ff, peak_in;
   logic [ID_W-1:0]  sub_ff, sub_in;
   logic [ID_W-1:0]  can_ff, can_in;
   logic [CNT_W-1:0] limit_ff;
   logic [LVL_W-1:0] normal_ff;
   logic             found_ff, found_in;
   logic [LVL_W-1:0] best_lvl_ff, best_lvl_in;
   logic [ID_W-1:0]  best_id_ff, best_id_in;
   logic [ID_W-1:0]  best_age_ff, best_age_in;
   logic [SLOT_W-1:0] best_idx_ff, best_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic [ENTRY_W-1:0] rd_entry;
   logic [LVL_W-1:0]   rd_lvl;
   logic [ID_W-1:0]    rd_id;
   logic [ID_W-1:0]    rd_age;
   logic               better;
   logic [SLOT_W-1:0]  free_idx;
   logic               free_any;
   logic [CNT_W-1:0]   limit_eff;
   logic [LVL_W-1:0]   sub_lvl;
   logic [LVL_W-1:0]   norm_sat;
   logic               sub_ok;
   logic               ram_we;

   stpq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_SLOTS)) u_slots (
      .clock (clock),
      .we    (ram_we),
      .waddr (free_idx),
      .wdata ({sub_lvl, next_id_ff}),
      .re    (cmd.rd_en),
      .raddr (cmd.rd_addr),
      .rdata (rd_entry)
   );

   assign rd_lvl   = rd_entry[ENTRY_W-1:ID_W];
   assign rd_id    = rd_entry[ID_W-1:0];
   assign rd_age   = next_id_ff - rd_id;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // A later slot wins only when strictly better, so ties go to the lowest slot.
   always_comb begin
      better = 1'b0;
      if (valid_ff[cmd.eval_idx]) begin
         if (kind_ff == KIND_DEQUEUE) begin
            better = !found_ff || (rd_lvl > best_lvl_ff) ||
                     ((rd_lvl == best_lvl_ff) && (rd_age > best_age_ff));
         end else begin
            better = !found_ff && (rd_id == want_ff);
         end
      end
   end

   always_comb begin
      free_idx = '0;
      free_any = 1'b0;
      for (int i = QUEUE_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = SLOT_W'(i);
            free_any = 1'b1;
         end
      end
   end

   always_comb begin
      if ({25'd0, limit_ff} > QUEUE_SLOTS) begin
         limit_eff = CNT_W'(QUEUE_SLOTS);
      end else begin
         limit_eff = limit_ff;
      end
      if ({30'd0, normal_ff} >= PRIORITY_LEVELS) begin
         norm_sat = LVL_W'(PRIORITY_LEVELS - 1);
      end else begin
         norm_sat = normal_ff;
      end
      if ({29'd0, prio_ff} >= PRIORITY_LEVELS) begin
         sub_lvl = norm_sat;
      end else begin
         sub_lvl = prio_ff[LVL_W-1:0];
      end
      sub_ok = (pending_ff < limit_eff) && free_any;
   end

   assign ram_we = cmd.finish && (kind_ff == KIND_SUBMIT) && sub_ok;

   always_comb begin
      valid_in     = valid_ff;
      next_id_in   = next_id_ff;
      pending_in   = pending_ff;
      peak_in      = peak_ff;
      sub_in       = sub_ff;
      can_in       = can_ff;
      found_in     = found_ff;
      best_lvl_in  = best_lvl_ff;
      best_id_in   = best_id_ff;
      best_age_in  = best_age_ff;
      best_idx_in  = best_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      if (cmd.load_req) begin
         found_in = 1'b0;
      end
      if (cmd.eval_en && better) begin
         found_in    = 1'b1;
         best_lvl_in = rd_lvl;
         best_id_in  = rd_id;
         best_age_in = rd_age;
         best_idx_in = cmd.eval_idx;
      end

      if (cmd.finish) begin
         rsp_in.status  = STAT_OK;
         rsp_in.task_id = '0;
         rsp_in.level   = '0;
         unique case (kind_ff)
            KIND_SUBMIT: begin
               if (sub_ok) begin
                  valid_in[free_idx] = 1'b1;
                  rsp_in.task_id     = next_id_ff;
                  rsp_in.level       = sub_lvl;
                  next_id_in         = next_id_ff + 1'b1;
                  if (next_id_in == '0) begin
                     next_id_in = ID_W'(1);
                  end
                  pending_in = pending_ff + 1'b1;
                  sub_in     = sub_ff + 1'b1;
                  if (pending_in > peak_ff) begin
                     peak_in = pending_in;
                  end
               end else begin
                  rsp_in.status = STAT_FULL;
               end
            end
            KIND_DEQUEUE, KIND_CANCEL: begin
               if (found_ff && !((kind_ff == KIND_CANCEL) && (want_ff == '0))) begin
                  valid_in[best_idx_ff] = 1'b0;
                  rsp_in.task_id        = best_id_ff;
                  rsp_in.level          = best_lvl_ff;
                  if (pending_ff != '0) begin
                     pending_in = pending_ff - 1'b1;
                  end
                  if (kind_ff == KIND_CANCEL) begin
                     can_in = can_ff + 1'b1;
                  end
               end else if (kind_ff == KIND_DEQUEUE) begin
                  rsp_in.status = STAT_EMPTY;
               end else begin
                  rsp_in.status = STAT_NOT_FOUND;
               end
            end
            default: begin
            end
         endcase
         rsp_in.queued_total    = pending_in;
         rsp_in.high_water      = peak_in;
         rsp_in.submitted_count = sub_in;
         rsp_in.cancelled_count = can_in;
         rsp_valid_in           = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         next_id_ff   <= ID_W'(1);
         pending_ff   <= '0;
         peak_ff      <= '0;
         sub_ff       <= '0;
         can_ff       <= '0;
         limit_ff     <= CNT_W'(64);
         normal_ff    <= LVL_W'(1);
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         next_id_ff   <= next_id_in;
         pending_ff   <= pending_in;
         peak_ff      <= peak_in;
         sub_ff       <= sub_in;
         can_ff       <= can_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_index == CSR_QUEUE_LIMIT) begin
            limit_ff <= csr_wdata;
         end
         if (csr_valid && csr_index == CSR_NORMAL_LEVEL) begin
            normal_ff <= csr_wdata[LVL_W-1:0];
         end
      end
      if (cmd.load_req) begin
         kind_ff <= req_data.kind;
         prio_ff <= req_data.priority_req;
         want_ff <= req_data.cancel_id;
      end
      best_lvl_ff <= best_lvl_in;
      best_id_ff  <= best_id_in;
      best_age_ff <= best_age_in;
      best_idx_ff <= best_idx_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

/* src/strict_priority_task_queue.sv */
// Top level of the strict-priority task queue.
// The queue holds up to 64 tasks at four levels. A submit, or an unused kind,
// loads its result into the output register once that register is free; a
// dequeue or cancel reads every slot of the slot RAM through its single read
// port, one slot a cycle, and then loads its result the same way.
// One item is handled at a time; the result waits in an output register and
// a new request is taken in the cycle after the previous result is loaded.
module strict_priority_task_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  stpq_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output stpq_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [6:0]        csr_wdata
);
   import stpq_pkg::*;

   cmd_type cmd;
   logic    out_free;

   assign csr_ready = 1'b1;

   stpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_data.kind),
      .out_free  (out_free),
      .cmd       (cmd)
   );

   stpq_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .out_free  (out_free),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // A failed request never names a task.
   a_fail_zero_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STAT_OK |-> rsp_data.task_id == '0)
      else $error("failed beat carries a task id");

   // The high-water mark never trails the pending total.
   a_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.high_water >= rsp_data.queued_total)
      else $error("high-water mark below pending total");

   // A result is only loaded while the output register is free.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> out_free)
      else $error("result overwrote a pending beat");
endmodule
